// File: hw/rtl/llc_pkg.sv
// shared types, constants and helpers for the local link cost block
package llc_pkg;

    localparam int PixW   = 24;
    localparam int ChanW  = 8;
    localparam int CostW  = 12;
    localparam int SumW   = 20;
    localparam int RadW   = 26;
    localparam int RootW  = 13;
    localparam int RemW   = 18;
    localparam int NDir   = 8;
    localparam int RootSteps = RadW / 2;

    // lane sequencing strobes
    typedef struct packed {
        logic acc;
        logic first;
        logic load;
        logic step;
    } t_lane_ctl;

    typedef logic [PixW-1:0] t_pix;

    // channel select: 0 red, 1 green, 2 blue
    function automatic logic [ChanW-1:0] f_chan(input t_pix px, input logic [1:0] ch);
        logic [ChanW-1:0] v;
        case (ch)
            2'd0: v = px[23:16];
            2'd1: v = px[15:8];
            default: v = px[7:0];
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/llc_lane.sv
// one direction lane: channel-serial sum of squares, then bit-serial root of T/3
module llc_lane (
    input  logic                    i_clk,
    input  llc_pkg::t_lane_ctl      i_ctl,
    input  logic                    i_diag,
    input  logic [7:0]              i_a1,
    input  logic [7:0]              i_a2,
    input  logic [7:0]              i_b1,
    input  logic [7:0]              i_b2,
    output logic [11:0]             o_root
);
    import llc_pkg::*;

    logic signed [17:0]  w_s;
    logic [17:0]         w_sq;
    logic [SumW-1:0]     r_sum;
    logic [RadW-1:0]     r_t;
    logic [RootW-1:0]    r_r;
    logic [RemW-1:0]     r_e;
    logic [RemW-1:0]     w_e4;
    logic [RemW-1:0]     w_trial;

    // signed channel difference, widened so its square fits
    assign w_s  = 18'($signed({2'b00, i_a1}) + $signed({2'b00, i_a2})
                - $signed({2'b00, i_b1}) - $signed({2'b00, i_b2}));
    assign w_sq = 18'(w_s * w_s);

    // next radicand digit and trial value 12r+3
    assign w_e4    = {r_e[RemW-3:0], r_t[RadW-1:RadW-2]};
    assign w_trial = RemW'({r_r, 3'b000} + {r_r, 2'b00}) + RemW'(3);

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc) begin
            r_sum <= i_ctl.first ? SumW'(w_sq) : r_sum + SumW'(w_sq);
        end
        if (i_ctl.load) begin
            r_t <= i_diag ? RadW'({r_sum, 7'b0}) : RadW'({r_sum, 4'b0});
            r_r <= '0;
            r_e <= '0;
        end else if (i_ctl.step) begin
            r_t <= {r_t[RadW-3:0], 2'b00};
            if (w_e4 >= w_trial) begin
                r_e <= w_e4 - w_trial;
                r_r <= {r_r[RootW-2:0], 1'b1};
            end else begin
                r_e <= w_e4;
                r_r <= {r_r[RootW-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_r[CostW-1:0];

endmodule

// File: hw/rtl/livewire_local_link_cost.sv
// top level: column window, job sequencer, eight cost lanes and result register
// Each column word is taken when the block is idle. A result is made by channel-serial
// squaring of the three channels, one load and 13 steps of the bit-serial square root
// run in each of the eight direction lanes, then a transfer into the output register
// once it is free. A column that ends a row after earlier columns makes two results and
// holds the input for both. The first column of a row makes no result unless it also
// ends the row. The output register holds a finished result while the next job runs.
module livewire_local_link_cost (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_top_red,
    input  logic [7:0]  i_top_green,
    input  logic [7:0]  i_top_blue,
    input  logic [7:0]  i_mid_red,
    input  logic [7:0]  i_mid_green,
    input  logic [7:0]  i_mid_blue,
    input  logic [7:0]  i_bot_red,
    input  logic [7:0]  i_bot_green,
    input  logic [7:0]  i_bot_blue,
    input  logic        i_has_above,
    input  logic        i_has_below,
    input  logic        i_row_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_cost_dir0,
    output logic [11:0] o_cost_dir1,
    output logic [11:0] o_cost_dir2,
    output logic [11:0] o_cost_dir3,
    output logic [11:0] o_cost_dir4,
    output logic [11:0] o_cost_dir5,
    output logic [11:0] o_cost_dir6,
    output logic [11:0] o_cost_dir7,
    output logic [7:0]  o_valid_mask,
    output logic [11:0] o_max_cost,
    output logic        o_row_last
);
    import llc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SQ   = 2'd1;
    localparam logic [1:0] S_RT   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  r_state;
    logic [3:0]  r_cnt;
    logic [1:0]  r_held;
    t_pix        r_win_l [3];
    t_pix        r_win_c [3];
    logic [1:0]  r_win_fl;
    // job operands
    t_pix        r_lc [3];
    t_pix        r_cc [3];
    t_pix        r_rc [3];
    logic        r_hl, r_hr, r_last, r_two;
    logic [1:0]  r_fl, r_fl2;
    // result register
    logic        r_ov;
    logic [CostW-1:0] r_cost [NDir];
    logic [7:0]  r_mask;
    logic [CostW-1:0] r_max;
    logic        r_rlast;

    t_pix        w_col [3];
    logic        w_acc_in, w_take;
    t_lane_ctl   w_ctl;
    logic [1:0]  w_ch;
    logic [7:0]  w_a1 [NDir];
    logic [7:0]  w_a2 [NDir];
    logic [7:0]  w_b1 [NDir];
    logic [7:0]  w_b2 [NDir];
    logic [CostW-1:0] w_root [NDir];
    logic [7:0]  w_mask;
    logic [CostW-1:0] w_cost [NDir];
    logic [CostW-1:0] w_max;
    logic        w_ha, w_hb;

    assign w_col[0] = {i_top_red, i_top_green, i_top_blue};
    assign w_col[1] = {i_mid_red, i_mid_green, i_mid_blue};
    assign w_col[2] = {i_bot_red, i_bot_green, i_bot_blue};

    assign o_stall  = (r_state != S_IDLE);
    assign w_acc_in = i_valid && (r_state == S_IDLE);
    assign w_take   = (r_state == S_OUT) && (!r_ov || !i_stall);
    assign w_ch     = r_cnt[1:0];

    // lane strobes
    always_comb begin
        w_ctl.acc   = (r_state == S_SQ);
        w_ctl.first = (r_state == S_SQ) && (r_cnt == 4'd0);
        w_ctl.load  = (r_state == S_RT) && (r_cnt == 4'd0);
        w_ctl.step  = (r_state == S_RT) && (r_cnt != 4'd0);
    end

    // per direction channel operands
    always_comb begin
        for (int d = 0; d < NDir; d++) begin
            w_a2[d] = '0;
            w_b2[d] = '0;
        end
        w_a1[0] = f_chan(r_lc[1], w_ch); w_b1[0] = f_chan(r_cc[0], w_ch);
        w_a1[1] = f_chan(r_lc[0], w_ch); w_a2[1] = f_chan(r_cc[0], w_ch);
        w_b1[1] = f_chan(r_lc[2], w_ch); w_b2[1] = f_chan(r_cc[2], w_ch);
        w_a1[2] = f_chan(r_lc[1], w_ch); w_b1[2] = f_chan(r_cc[2], w_ch);
        w_a1[3] = f_chan(r_lc[2], w_ch); w_a2[3] = f_chan(r_lc[1], w_ch);
        w_b1[3] = f_chan(r_rc[2], w_ch); w_b2[3] = f_chan(r_rc[1], w_ch);
        w_a1[4] = f_chan(r_rc[1], w_ch); w_b1[4] = f_chan(r_cc[2], w_ch);
        w_a1[5] = f_chan(r_rc[0], w_ch); w_a2[5] = f_chan(r_cc[0], w_ch);
        w_b1[5] = f_chan(r_rc[2], w_ch); w_b2[5] = f_chan(r_cc[2], w_ch);
        w_a1[6] = f_chan(r_rc[1], w_ch); w_b1[6] = f_chan(r_cc[0], w_ch);
        w_a1[7] = f_chan(r_lc[0], w_ch); w_a2[7] = f_chan(r_lc[1], w_ch);
        w_b1[7] = f_chan(r_rc[0], w_ch); w_b2[7] = f_chan(r_rc[1], w_ch);
    end

    // cost lanes, even directions are diagonal
    for (genvar g = 0; g < NDir; g++) begin : g_lane
        llc_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_diag ((g % 2) == 0),
            .i_a1   (w_a1[g]),
            .i_a2   (w_a2[g]),
            .i_b1   (w_b1[g]),
            .i_b2   (w_b2[g]),
            .o_root (w_root[g])
        );
    end

    // direction validity, masked costs and maximum
    always_comb begin
        w_ha = r_fl[0];
        w_hb = r_fl[1];
        w_mask[0] = r_hl && w_ha;
        w_mask[1] = r_hl && w_ha && w_hb;
        w_mask[2] = r_hl && w_hb;
        w_mask[3] = r_hl && r_hr && w_hb;
        w_mask[4] = r_hr && w_hb;
        w_mask[5] = r_hr && w_ha && w_hb;
        w_mask[6] = r_hr && w_ha;
        w_mask[7] = r_hl && r_hr && w_ha;
        w_max = '0;
        for (int d = 0; d < NDir; d++) begin
            w_cost[d] = w_mask[d] ? w_root[d] : '0;
            if (w_cost[d] > w_max) w_max = w_cost[d];
        end
    end

    // sequencer and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_held   <= '0;
            r_win_fl <= '0;
            r_two    <= 1'b0;
            r_ov     <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_win_l[k] <= '0;
                r_win_c[k] <= '0;
            end
        end else begin
            // output word valid: set on a new result, cleared when taken
            if (w_take) r_ov <= 1'b1;
            else if (o_valid && !i_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        r_cnt <= '0;
                        if (r_held == 2'd0) begin
                            for (int k = 0; k < 3; k++) begin
                                r_lc[k] <= '0;
                                r_cc[k] <= w_col[k];
                                r_rc[k] <= '0;
                            end
                            r_hl   <= 1'b0;
                            r_hr   <= 1'b0;
                            r_fl   <= {i_has_below, i_has_above};
                            r_last <= 1'b1;
                            r_two  <= 1'b0;
                            if (i_row_end) r_state <= S_SQ;
                        end else begin
                            for (int k = 0; k < 3; k++) begin
                                r_lc[k] <= r_win_l[k];
                                r_cc[k] <= r_win_c[k];
                                r_rc[k] <= w_col[k];
                            end
                            r_hl    <= (r_held == 2'd2);
                            r_hr    <= 1'b1;
                            r_fl    <= r_win_fl;
                            r_last  <= 1'b0;
                            r_two   <= i_row_end;
                            r_fl2   <= {i_has_below, i_has_above};
                            r_state <= S_SQ;
                        end
                        for (int k = 0; k < 3; k++) begin
                            r_win_l[k] <= r_win_c[k];
                            r_win_c[k] <= w_col[k];
                        end
                        r_win_fl <= {i_has_below, i_has_above};
                        if (i_row_end) r_held <= '0;
                        else if (r_held != 2'd2) r_held <= r_held + 2'd1;
                    end
                end
                S_SQ: begin
                    if (r_cnt == 4'd2) begin
                        r_cnt   <= '0;
                        r_state <= S_RT;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_RT: begin
                    if (r_cnt == 4'(RootSteps)) begin
                        r_cnt   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_OUT: begin
                    if (w_take) begin
                        if (r_two) begin
                            // second result of a row end: shift the job one column left
                            for (int k = 0; k < 3; k++) begin
                                r_lc[k] <= r_cc[k];
                                r_cc[k] <= r_rc[k];
                                r_rc[k] <= '0;
                            end
                            r_hl    <= 1'b1;
                            r_hr    <= 1'b0;
                            r_fl    <= r_fl2;
                            r_last  <= 1'b1;
                            r_two   <= 1'b0;
                            r_state <= S_SQ;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            for (int d = 0; d < NDir; d++) r_cost[d] <= w_cost[d];
            r_mask  <= w_mask;
            r_max   <= w_max;
            r_rlast <= r_last;
        end
    end

    assign o_valid      = r_ov;
    assign o_cost_dir0  = r_cost[0];
    assign o_cost_dir1  = r_cost[1];
    assign o_cost_dir2  = r_cost[2];
    assign o_cost_dir3  = r_cost[3];
    assign o_cost_dir4  = r_cost[4];
    assign o_cost_dir5  = r_cost[5];
    assign o_cost_dir6  = r_cost[6];
    assign o_cost_dir7  = r_cost[7];
    assign o_valid_mask = r_mask;
    assign o_max_cost   = r_max;
    assign o_row_last   = r_rlast;

endmodule

// File: bench/testbench.sv
// testbench for the local link cost block: scoreboard class, drivers and checks
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [11:0] cost [8];
        logic [7:0]  mask;
        logic [11:0] peak;
        logic        last;
    } t_link_costs;

    typedef struct {
        logic [23:0] px [3];
        logic        above;
        logic        below;
        logic        row_end;
    } t_column;

    // holds the column window and the costs still owed by the block
    class link_cost_board;
        t_link_costs pending_costs [$];
        logic [23:0] win_left [3];
        logic [23:0] win_mid [3];
        logic [1:0]  mid_flags;
        int          held;
        int          errors;

        function new();
            for (int r = 0; r < 3; r++) begin
                win_left[r] = '0;
                win_mid[r] = '0;
            end
            mid_flags = '0;
            held = 0;
            errors = 0;
        endfunction

        function int chan_of(logic [23:0] px, int ch);
            return int'(px[16-8*ch +: 8]);
        endfunction

        function int int_root(int v);
            int r;
            r = 0;
            while ((r + 1) * (r + 1) <= v) r++;
            return r;
        endfunction

        function logic [11:0] diag_deriv(logic [23:0] a, logic [23:0] b);
            int sum, d;
            sum = 0;
            for (int ch = 0; ch < 3; ch++) begin
                d = chan_of(a, ch) - chan_of(b, ch);
                sum += d * d;
            end
            return 12'(int_root((128 * sum) / 3));
        endfunction

        function logic [11:0] axial_deriv(logic [23:0] a1, logic [23:0] a2,
                                          logic [23:0] b1, logic [23:0] b2);
            int sum, s;
            sum = 0;
            for (int ch = 0; ch < 3; ch++) begin
                s = chan_of(a1, ch) + chan_of(a2, ch) - chan_of(b1, ch) - chan_of(b2, ch);
                sum += s * s;
            end
            return 12'(int_root((16 * sum) / 3));
        endfunction

        function t_link_costs link_costs(logic [23:0] lc [3], logic [23:0] cc [3],
                                         logic [23:0] rc [3], bit hl, bit hr,
                                         logic [1:0] fl, bit last);
            t_link_costs res;
            bit ha, hb;
            logic [7:0] m;
            ha = fl[0];
            hb = fl[1];
            m = {hl && hr && ha, hr && ha, hr && ha && hb, hr && hb,
                 hl && hr && hb, hl && hb, hl && ha && hb, hl && ha};
            for (int d = 0; d < 8; d++) res.cost[d] = '0;
            if (m[0]) res.cost[0] = diag_deriv(lc[1], cc[0]);
            if (m[1]) res.cost[1] = axial_deriv(lc[0], cc[0], lc[2], cc[2]);
            if (m[2]) res.cost[2] = diag_deriv(lc[1], cc[2]);
            if (m[3]) res.cost[3] = axial_deriv(lc[2], lc[1], rc[2], rc[1]);
            if (m[4]) res.cost[4] = diag_deriv(rc[1], cc[2]);
            if (m[5]) res.cost[5] = axial_deriv(rc[0], cc[0], rc[2], cc[2]);
            if (m[6]) res.cost[6] = diag_deriv(rc[1], cc[0]);
            if (m[7]) res.cost[7] = axial_deriv(lc[0], lc[1], rc[0], rc[1]);
            res.mask = m;
            res.peak = '0;
            for (int d = 0; d < 8; d++)
                if (m[d] && res.cost[d] > res.peak) res.peak = res.cost[d];
            res.last = last;
            return res;
        endfunction

        // slide the window and queue whatever this column completes
        function void note_column(t_column c);
            logic [23:0] none [3];
            logic [1:0] fl;
            for (int r = 0; r < 3; r++) none[r] = '0;
            fl = {c.below, c.above};
            if (held == 0) begin
                if (c.row_end)
                    pending_costs.push_back(link_costs(none, c.px, none, 0, 0, fl, 1));
            end else begin
                pending_costs.push_back(link_costs(win_left, win_mid, c.px, held >= 2, 1,
                                                   mid_flags, 0));
                if (c.row_end)
                    pending_costs.push_back(link_costs(win_mid, c.px, none, 1, 0, fl, 1));
            end
            win_left = win_mid;
            win_mid = c.px;
            mid_flags = fl;
            if (c.row_end) held = 0;
            else if (held < 2) held++;
        endfunction

        function void check_costs(t_link_costs got);
            t_link_costs want;
            if (pending_costs.size() == 0) begin
                $display("%0t: unexpected word mask %h max %0d", $time, got.mask, got.peak);
                errors++;
                return;
            end
            want = pending_costs.pop_front();
            for (int d = 0; d < 8; d++)
                if (got.cost[d] !== want.cost[d]) begin
                    $display("%0t: cost_dir%0d expected %0d actual %0d", $time, d,
                             want.cost[d], got.cost[d]);
                    errors++;
                end
            if (got.mask !== want.mask) begin
                $display("%0t: valid_mask expected %h actual %h", $time, want.mask, got.mask);
                errors++;
            end
            if (got.peak !== want.peak) begin
                $display("%0t: max_cost expected %0d actual %0d", $time, want.peak, got.peak);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: row_last expected %b actual %b", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_top_red, i_top_green, i_top_blue;
    logic [7:0]  i_mid_red, i_mid_green, i_mid_blue;
    logic [7:0]  i_bot_red, i_bot_green, i_bot_blue;
    logic        i_has_above, i_has_below, i_row_end;
    logic        o_valid;
    logic        i_stall;
    logic [11:0] o_cost_dir0, o_cost_dir1, o_cost_dir2, o_cost_dir3;
    logic [11:0] o_cost_dir4, o_cost_dir5, o_cost_dir6, o_cost_dir7;
    logic [7:0]  o_valid_mask;
    logic [11:0] o_max_cost;
    logic        o_row_last;

    link_cost_board board;
    bit          stim_done;

    livewire_local_link_cost uut (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("livewire_local_link_cost test failed");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    function automatic logic [23:0] rand_pixel(int kind);
        case (kind)
            0: return 24'h000000;
            1: return 24'hffffff;
            default: return 24'($urandom);
        endcase
    endfunction

    // present one column word and hold it until the block takes it
    task automatic send_column(t_column c);
        int g;
        {i_top_red, i_top_green, i_top_blue} <= c.px[0];
        {i_mid_red, i_mid_green, i_mid_blue} <= c.px[1];
        {i_bot_red, i_bot_green, i_bot_blue} <= c.px[2];
        i_has_above <= c.above;
        i_has_below <= c.below;
        i_row_end <= c.row_end;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        board.note_column(c);
        g = gap_len();
        if (g != 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_row(int cols, int kind, bit above, bit below);
        t_column c;
        for (int k = 0; k < cols; k++) begin
            for (int r = 0; r < 3; r++) c.px[r] = rand_pixel(kind);
            c.above = above;
            c.below = below;
            c.row_end = (k == cols - 1);
            send_column(c);
        end
    endtask

    // result side: random stall and field-wise check
    initial begin
        t_link_costs got;
        int hold;
        i_stall = 1'b1;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.cost[0] = o_cost_dir0; got.cost[1] = o_cost_dir1;
                got.cost[2] = o_cost_dir2; got.cost[3] = o_cost_dir3;
                got.cost[4] = o_cost_dir4; got.cost[5] = o_cost_dir5;
                got.cost[6] = o_cost_dir6; got.cost[7] = o_cost_dir7;
                got.mask = o_valid_mask;
                got.peak = o_max_cost;
                got.last = o_row_last;
                board.check_costs(got);
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else if (!stim_done && $urandom_range(2) == 0) begin
                hold = gap_len();
                i_stall <= (hold != 0);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_column c;
        int sent, cols, lim;
        board = new();
        stim_done = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        {i_top_red, i_top_green, i_top_blue} <= '0;
        {i_mid_red, i_mid_green, i_mid_blue} <= '0;
        {i_bot_red, i_bot_green, i_bot_blue} <= '0;
        i_has_above <= 1'b0;
        i_has_below <= 1'b0;
        i_row_end <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single-column row, extremes, edge flags, two-column row
        send_row(1, 2, 1, 1);
        send_row(3, 1, 1, 1);
        send_row(3, 0, 1, 1);
        for (int k = 0; k < 4; k++) begin
            for (int r = 0; r < 3; r++) c.px[r] = (k % 2) ? 24'hffffff : 24'h000000;
            c.above = 1; c.below = 1; c.row_end = (k == 3);
            send_column(c);
        end
        send_row(3, 2, 0, 1);
        send_row(3, 2, 1, 0);
        send_row(2, 2, 0, 0);
        send_row(2, 2, 1, 1);

        // drain fully before random traffic
        i_valid <= 1'b0;
        while (board.pending_costs.size() != 0) @(posedge i_clk);

        sent = 0;
        while (sent < 1900) begin
            cols = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
            send_row(cols, $urandom_range(9) < 8 ? 2 : $urandom_range(1),
                     $urandom_range(5) != 0, $urandom_range(5) != 0);
            sent += cols;
        end

        i_valid <= 1'b0;
        stim_done = 1;
        lim = 0;
        while (board.pending_costs.size() != 0 && lim < 100000) begin
            @(posedge i_clk);
            lim++;
        end
        repeat (60) @(posedge i_clk);
        if (board.errors == 0 && board.pending_costs.size() == 0)
            $display("livewire_local_link_cost test passed");
        else
            $display("livewire_local_link_cost test failed");
        $finish;
    end
endmodule
